>>> hdl/pwli_pkg.sv
// Shared types and constants for the piecewise linear interpolation table.
`default_nettype none
package pwli_pkg;

  // field widths
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned STAT_W = 2;

  // slope divider widths: |dy| * 2^16 over |dx|
  localparam int unsigned DIV_NUM_W = 49;
  localparam int unsigned DIV_DEN_W = 33;

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_SAT   = 2'd2;

  typedef struct packed {
    logic                     operation;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] entry_x;
    logic signed [DATA_W-1:0] entry_y;
    logic signed [DATA_W-1:0] query_x;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_y;
    logic [STAT_W-1:0]        status;
  } out_t;

endpackage
`default_nettype wire

>>> hdl/pwli_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module pwli_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/pwli_div.sv
// Restoring unsigned divider, one quotient bit per cycle, for the segment slope.
`default_nettype none
module pwli_div (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [pwli_pkg::DIV_NUM_W-1:0]  num,
  input  wire logic [pwli_pkg::DIV_DEN_W-1:0]  den,
  output logic                                 done,
  output logic [pwli_pkg::DIV_NUM_W-1:0]       quot
);

  localparam int unsigned NW  = pwli_pkg::DIV_NUM_W;
  localparam int unsigned DW  = pwli_pkg::DIV_DEN_W;
  localparam int unsigned RW  = DW + 1;
  localparam int unsigned CW  = $clog2(NW);

  logic          active_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] num_r;
  logic [DW-1:0] den_r;
  logic [RW-1:0] rem_r;
  logic [NW-1:0] quot_r;

  logic [RW-1:0] rem_sh;
  logic          ge;
  logic [RW-1:0] rem_nxt;

  // shift in the next dividend bit and trial-subtract
  always_comb begin
    rem_sh  = {rem_r[RW-2:0], num_r[NW-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        active_r <= 1'b1;
        cnt_r    <= '0;
      end else if (active_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (active_r) begin
      rem_r  <= rem_nxt;
      num_r  <= {num_r[NW-2:0], 1'b0};
      quot_r <= {quot_r[NW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

  // the remainder always stays below the divisor between steps
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    active_r && !start |=> (rem_r < {1'b0, den_r}))
    else $error("divider remainder not below divisor");

endmodule
`default_nettype wire

>>> hdl/piecewise_linear_interp_extrap_top.sv
// Top level of the piecewise linear interpolation and extrapolation table.
`default_nettype none
// Breakpoints (x, y in signed Q16.16) live in two synchronous RAMs and are written by
// load transactions, which give no result. A query transaction binary-searches the x
// RAM with one read per search step, reads the bracketing segment and divides
// dy * 2^16 by dx in a one-bit-per-cycle divider, then multiplies twice through one
// shared 32x32 multiplier. An empty table answers without leaving idle and a single
// point is read back without a search. busy is high while a query is in flight.
// Each result shows on out_data for one cycle with out_valid high and cannot be held
// off; a new transaction may start while it is shown. point_count is to be written
// through cfg_we only while the block is idle; the block itself does not enforce this.
module piecewise_linear_interp_extrap_top #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire pwli_pkg::in_t                 in_data,
  output logic                               out_valid,
  output pwli_pkg::out_t                     out_data,
  input  wire logic                          cfg_we,
  input  wire logic [pwli_pkg::CNT_W-1:0]    cfg_wdata
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = pwli_pkg::CNT_W;
  localparam int unsigned DW = pwli_pkg::DATA_W;

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_SRD     = 16'h0002,
    S_SCMP    = 16'h0004,
    S_NRD0    = 16'h0008,
    S_NRD1    = 16'h0010,
    S_NSEL    = 16'h0020,
    S_ARD     = 16'h0040,
    S_BRD     = 16'h0080,
    S_BCAP    = 16'h0100,
    S_DIVGO   = 16'h0200,
    S_DIV     = 16'h0400,
    S_MUL1    = 16'h0800,
    S_MUL2    = 16'h1000,
    S_SUM     = 16'h2000,
    S_ONE_RD  = 16'h4000,
    S_ONE_CAP = 16'h8000
  } state_t;

  // truncate a Q32.32 product toward zero to Q32.16
  function automatic logic signed [47:0] trunc16(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + (p[63] ? 64'sd65535 : 64'sd0);
    return t[63:16];
  endfunction

  state_t state_r, state_nxt;

  logic [CW-1:0]          count_r;
  logic [CW-1:0]          n_r;
  logic [CW-1:0]          lo_r, hi_r, mid_r, idx_r;
  logic signed [DW-1:0]   q_r;
  logic [DW-1:0]          xlm1_r, txi_r, xa_r, ya_r, yi_r;
  logic signed [32:0]     dx_r, dy_r;
  logic signed [DW-1:0]   m_r;
  logic                   sat_r;
  logic signed [63:0]     prod_r;
  logic signed [48:0]     icpt_r;
  logic                   out_valid_r;
  pwli_pkg::out_t         out_data_r;

  logic                   accept;
  logic [CW-1:0]          n_val;
  logic [CW-1:0]          mid_val;
  logic [CW-1:0]          rd_idx;
  logic                   ram_we;
  logic [DW-1:0]          x_rdata, y_rdata;
  logic [CW-1:0]          lo_nxt, hi_nxt;
  logic [CW-1:0]          seg_a, seg_b;
  logic                   a_is_idx;
  logic [32:0]            dist_lo_m1, dist_lo;
  logic signed [32:0]     d_lo_m1, d_lo;
  logic                   div_start, div_done;
  logic [pwli_pkg::DIV_NUM_W-1:0] div_quot;
  logic [32:0]            abs_dx, abs_dy;
  logic                   neg_m;
  logic signed [49:0]     sum_y;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // clamp the configured count to the table depth
  assign n_val = (32'(count_r) > MAX_POINTS) ? CW'(MAX_POINTS) : count_r;
  assign mid_val = CW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);

  // load transactions write one entry in both RAMs
  assign ram_we = accept && (in_data.operation == pwli_pkg::OP_LOAD) &&
                  (32'(in_data.entry_index) < MAX_POINTS);

  // pick the read address for each step
  always_comb begin
    case (state_r)
      S_SRD:   rd_idx = mid_val;
      S_NRD0:  rd_idx = lo_r - 1'b1;
      S_NRD1:  rd_idx = lo_r;
      S_ARD:   rd_idx = seg_a;
      S_BRD:   rd_idx = seg_b;
      default: rd_idx = '0;
    endcase
  end

  pwli_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_data.entry_index)),
    .wdata (in_data.entry_x),
    .raddr (AW'(rd_idx)),
    .rdata (x_rdata)
  );

  pwli_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_data.entry_index)),
    .wdata (in_data.entry_y),
    .raddr (AW'(rd_idx)),
    .rdata (y_rdata)
  );

  // binary search step
  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if ($signed(x_rdata) < q_r) begin
      lo_nxt = mid_r + 1'b1;
    end else begin
      hi_nxt = mid_r;
    end
  end

  // distances to the two neighbors of the lower bound
  always_comb begin
    d_lo_m1    = {q_r[DW-1], q_r} - {xlm1_r[DW-1], xlm1_r};
    d_lo       = {q_r[DW-1], q_r} - {x_rdata[DW-1], x_rdata};
    dist_lo_m1 = d_lo_m1[32] ? 33'(-d_lo_m1) : 33'(d_lo_m1);
    dist_lo    = d_lo[32] ? 33'(-d_lo) : 33'(d_lo);
  end

  // segment around the chosen neighbor
  always_comb begin
    if ($signed(txi_r) > q_r) begin
      if (idx_r != '0) begin
        seg_a = idx_r - 1'b1;
        seg_b = idx_r;
      end else begin
        seg_a = idx_r;
        seg_b = idx_r + 1'b1;
      end
    end else if (idx_r < n_r - 1'b1) begin
      seg_a = idx_r;
      seg_b = idx_r + 1'b1;
    end else begin
      seg_a = idx_r - 1'b1;
      seg_b = idx_r;
    end
    a_is_idx = (seg_a == idx_r);
  end

  // slope divider on magnitudes
  assign abs_dx    = dx_r[32] ? 33'(-dx_r) : 33'(dx_r);
  assign abs_dy    = dy_r[32] ? 33'(-dy_r) : 33'(dy_r);
  assign neg_m     = dx_r[32] ^ dy_r[32];
  assign div_start = (state_r == S_DIVGO) && (dx_r != '0);

  pwli_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({abs_dy, 16'h0000}),
    .den   (abs_dx),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign sum_y = 50'(trunc16(prod_r)) + 50'(icpt_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_data.operation == pwli_pkg::OP_QUERY)) begin
          if (n_val == CW'(1)) begin
            state_nxt = S_ONE_RD;
          end else if (n_val != '0) begin
            state_nxt = S_SRD;
          end
        end
      end
      S_SRD:     state_nxt = S_SCMP;
      S_SCMP:    state_nxt = (lo_nxt < hi_nxt) ? S_SRD : S_NRD0;
      S_NRD0:    state_nxt = S_NRD1;
      S_NRD1:    state_nxt = S_NSEL;
      S_NSEL:    state_nxt = S_ARD;
      S_ARD:     state_nxt = S_BRD;
      S_BRD:     state_nxt = S_BCAP;
      S_BCAP:    state_nxt = S_DIVGO;
      S_DIVGO:   state_nxt = (dx_r == '0) ? S_MUL1 : S_DIV;
      S_DIV:     state_nxt = div_done ? S_MUL1 : S_DIV;
      S_MUL1:    state_nxt = S_MUL2;
      S_MUL2:    state_nxt = S_SUM;
      S_SUM:     state_nxt = S_IDLE;
      S_ONE_RD:  state_nxt = S_ONE_CAP;
      S_ONE_CAP: state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
      if (accept && (in_data.operation == pwli_pkg::OP_QUERY) && (n_val == '0)) begin
        out_valid_r <= 1'b1;
      end
      if ((state_r == S_SUM) || (state_r == S_ONE_CAP)) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        q_r    <= in_data.query_x;
        n_r    <= n_val;
        lo_r   <= '0;
        hi_r   <= n_val;
        sat_r  <= 1'b0;
        out_data_r.result_y <= '0;
        out_data_r.status   <= pwli_pkg::ST_EMPTY;
      end
      S_SRD:  mid_r <= mid_val;
      S_SCMP: begin
        lo_r <= lo_nxt;
        hi_r <= hi_nxt;
      end
      S_NRD1: xlm1_r <= x_rdata;
      S_NSEL: begin
        if (lo_r == '0) begin
          idx_r <= '0;
          txi_r <= x_rdata;
        end else if (lo_r == n_r) begin
          idx_r <= n_r - 1'b1;
          txi_r <= xlm1_r;
        end else if (dist_lo_m1 < dist_lo) begin
          idx_r <= lo_r - 1'b1;
          txi_r <= xlm1_r;
        end else begin
          idx_r <= lo_r;
          txi_r <= x_rdata;
        end
      end
      S_BRD: begin
        xa_r <= x_rdata;
        ya_r <= y_rdata;
      end
      S_BCAP: begin
        dx_r <= {x_rdata[DW-1], x_rdata} - {xa_r[DW-1], xa_r};
        dy_r <= {y_rdata[DW-1], y_rdata} - {ya_r[DW-1], ya_r};
        yi_r <= a_is_idx ? ya_r : y_rdata;
      end
      S_DIVGO: begin
        if (dx_r == '0) begin
          m_r <= '0;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (neg_m) begin
            if (div_quot > 49'h0_0000_8000_0000) begin
              m_r   <= 32'sh8000_0000;
              sat_r <= 1'b1;
            end else begin
              m_r <= -$signed(div_quot[DW-1:0]);
            end
          end else begin
            if (div_quot > 49'h0_0000_7FFF_FFFF) begin
              m_r   <= 32'sh7FFF_FFFF;
              sat_r <= 1'b1;
            end else begin
              m_r <= $signed(div_quot[DW-1:0]);
            end
          end
        end
      end
      S_MUL1: prod_r <= $signed(txi_r) * m_r;
      S_MUL2: begin
        prod_r <= q_r * m_r;
        icpt_r <= 49'($signed(yi_r)) - 49'(trunc16(prod_r));
      end
      S_SUM: begin
        if (sum_y > 50'sh0_7FFF_FFFF) begin
          out_data_r.result_y <= 32'sh7FFF_FFFF;
          out_data_r.status   <= pwli_pkg::ST_SAT;
        end else if (sum_y < -50'sh0_8000_0000) begin
          out_data_r.result_y <= 32'sh8000_0000;
          out_data_r.status   <= pwli_pkg::ST_SAT;
        end else begin
          out_data_r.result_y <= sum_y[DW-1:0];
          out_data_r.status   <= sat_r ? pwli_pkg::ST_SAT : pwli_pkg::ST_OK;
        end
      end
      S_ONE_CAP: begin
        out_data_r.result_y <= y_rdata;
        out_data_r.status   <= pwli_pkg::ST_OK;
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // search window stays ordered and inside the table
  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRD || state_r == S_SCMP) |-> (lo_r < hi_r) && (hi_r <= n_r))
    else $error("binary search window out of order");

  // the chosen segment lies inside the table in use
  a_segment_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ARD) |-> (seg_b == seg_a + 1'b1) && (seg_b < n_r))
    else $error("segment outside table");

  // a result only follows a finished computation or an empty-table query
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_SUM) || $past(state_r == S_ONE_CAP) ||
                    (out_data_r.status == pwli_pkg::ST_EMPTY))
    else $error("result without a source");

  // the divider only reports while a slope is awaited
  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider done outside slope wait");

endmodule
`default_nettype wire
